>>> rtl/apnsd_pkg.sv
package apnsd_pkg;

    // Sample pairs decoded from one packet before the rest is skipped.
    localparam logic [11:0] PAIRS_PER_PACKET = 12'd1024;

    // Byte that escapes to a raw big-endian sample.
    localparam logic [7:0] ESCAPE_BYTE = 8'h80;

    // Packet byte positions that carry the length and the shift header.
    localparam logic [16:0] POS_LEN_HIGH = 17'd0;
    localparam logic [16:0] POS_LEN_LOW  = 17'd1;
    localparam logic [16:0] POS_HEADER   = 17'd2;

    // Progress through an escaped sample.
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc_phase;

    // One result item as it travels to the output register.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               channel;
        logic               last_in_packet;
        logic               packet_short;
    } t_result;

endpackage

>>> rtl/apnsd_in_stage.sv
module apnsd_in_stage
    import apnsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_advance,
    output logic       o_ready,
    output logic       o_full,
    output logic [7:0] o_data_byte
);

    logic       r_valid;
    logic [7:0] r_data_byte;

    // The stage takes a new byte whenever it is empty or its byte moves on.
    assign o_ready     = !r_valid || i_advance;
    assign o_full      = r_valid;
    assign o_data_byte = r_data_byte;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register, loaded on every input transfer.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data_byte <= i_data_byte;
        end
    end

endmodule

>>> rtl/apnsd_core.sv
module apnsd_core
    import apnsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_data_byte,
    output t_result    o_result
);

    logic [16:0] r_pos;
    logic [15:0] r_len;
    logic [3:0]  r_shift_first;
    logic [3:0]  r_shift_second;
    t_esc_phase  r_esc;
    logic [7:0]  r_esc_high;
    logic [11:0] r_done;
    logic        r_half;

    logic [16:0] n_pos;
    logic [15:0] n_len;
    logic [3:0]  n_shift_first;
    logic [3:0]  n_shift_second;
    t_esc_phase  n_esc;
    logic [7:0]  n_esc_high;
    logic [11:0] n_done;
    logic        n_half;

    logic        emit;
    logic [15:0] smp;
    logic [15:0] ext;
    logic [3:0]  shift;
    logic        packet_end;

    // Sign-extended byte shifted by the nibble for this half of the pair.
    assign shift = r_half ? r_shift_second : r_shift_first;
    assign ext   = {{8{i_data_byte[7]}}, i_data_byte};

    // Decode of one byte and next packet state.
    always_comb begin
        n_pos          = r_pos;
        n_len          = r_len;
        n_shift_first  = r_shift_first;
        n_shift_second = r_shift_second;
        n_esc          = r_esc;
        n_esc_high     = r_esc_high;
        n_done         = r_done;
        n_half         = r_half;
        emit           = 1'b0;
        smp            = 16'd0;
        o_result       = '0;

        if (r_pos == POS_LEN_HIGH) begin
            n_len = {i_data_byte, 8'd0};
        end else if (r_pos == POS_LEN_LOW) begin
            n_len = {r_len[15:8], i_data_byte};
        end else if (r_pos == POS_HEADER) begin
            n_shift_first  = i_data_byte[7:4];
            n_shift_second = i_data_byte[3:0];
        end else if (r_done < PAIRS_PER_PACKET) begin
            case (r_esc)
                ESC_HIGH: begin
                    n_esc_high = i_data_byte;
                    n_esc      = ESC_LOW;
                end
                ESC_LOW: begin
                    smp   = {r_esc_high, i_data_byte};
                    n_esc = ESC_NONE;
                    emit  = 1'b1;
                end
                default: begin
                    if (i_data_byte == ESCAPE_BYTE) begin
                        n_esc = ESC_HIGH;
                    end else begin
                        smp  = ext << shift;
                        emit = 1'b1;
                    end
                end
            endcase
            if (emit) begin
                o_result.sample_valid = 1'b1;
                o_result.sample       = smp;
                o_result.channel      = r_half;
                if (r_half) begin
                    n_done                  = r_done + 12'd1;
                    o_result.last_in_packet = (n_done == PAIRS_PER_PACKET);
                end
                n_half = !r_half;
            end
        end

        // The packet ends on the byte whose position equals length plus one.
        packet_end = (r_pos != POS_LEN_HIGH) && (r_pos == ({1'b0, n_len} + 17'd1));
        if (packet_end) begin
            o_result.packet_short = (n_done < PAIRS_PER_PACKET);
            n_pos      = '0;
            n_len      = '0;
            n_esc      = ESC_NONE;
            n_esc_high = '0;
            n_done     = '0;
            n_half     = 1'b0;
        end else begin
            n_pos = r_pos + 17'd1;
        end
    end

    // Packet state, stepped once for each byte that leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_len          <= '0;
            r_shift_first  <= '0;
            r_shift_second <= '0;
            r_esc          <= ESC_NONE;
            r_esc_high     <= '0;
            r_done         <= '0;
            r_half         <= 1'b0;
        end else if (i_advance) begin
            r_pos          <= n_pos;
            r_len          <= n_len;
            r_shift_first  <= n_shift_first;
            r_shift_second <= n_shift_second;
            r_esc          <= n_esc;
            r_esc_high     <= n_esc_high;
            r_done         <= n_done;
            r_half         <= n_half;
        end
    end

endmodule

>>> rtl/apnsd_out_stage.sv
module apnsd_out_stage
    import apnsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // A new result may enter when the register is empty or is being read out.
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> rtl/audio_packet_nibble_shift_decoder.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_data_byte, i_chunk_end
// result    out        o_valid / i_ready    o_sample, o_sample_valid, o_channel,
//                                           o_last_in_packet, o_packet_short
//
// Every input byte gives exactly one result item: the byte is held in the input
// register, and its result then in the result register. One byte per cycle is
// sustained while the output side is ready; the packet state steps as a byte
// moves from the input register into the result register.
// Reset is synchronous and active low and clears the packet state and both
// occupancy flags. A stalled output holds its result while the input register
// still takes one more byte.
module audio_packet_nibble_shift_decoder
    import apnsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_chunk_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample,
    output logic               o_sample_valid,
    output logic               o_channel,
    output logic               o_last_in_packet,
    output logic               o_packet_short
);

    logic       in_full;
    logic [7:0] in_byte;
    logic       out_can_load;
    logic       advance;
    t_result    core_result;
    t_result    out_result;

    // The end of a container chunk does not change the packet state.
    logic       chunk_end_unused;
    assign chunk_end_unused = i_chunk_end;

    // A byte moves on when the result register can take its result.
    assign advance = in_full && out_can_load;

    apnsd_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_advance   (advance),
        .o_ready     (o_ready),
        .o_full      (in_full),
        .o_data_byte (in_byte)
    );

    apnsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_data_byte (in_byte),
        .o_result    (core_result)
    );

    apnsd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (core_result),
        .i_ready    (i_ready),
        .o_can_load (out_can_load),
        .o_valid    (o_valid),
        .o_result   (out_result)
    );

    assign o_sample         = out_result.sample;
    assign o_sample_valid   = out_result.sample_valid;
    assign o_channel        = out_result.channel;
    assign o_last_in_packet = out_result.last_in_packet;
    assign o_packet_short   = out_result.packet_short;

    // A result without a sample carries no sample, channel or last flag.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sample_valid |-> o_sample == 16'd0 && !o_channel && !o_last_in_packet)
        else $error("result without a sample carries sample fields");

    // The last sample of a run closes a pair.
    a_last_is_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_in_packet |-> o_sample_valid && o_channel)
        else $error("last sample of a run is not the second of a pair");

    // A full run can never also be short.
    a_last_not_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_last_in_packet && o_packet_short))
        else $error("packet flagged both complete and short");

    // With both registers full and the output stalled, no byte is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_full && o_valid && !i_ready |-> !o_ready)
        else $error("input transfer taken while the pipeline is blocked");

    // A stalled output does not let the packet state move.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !advance)
        else $error("byte decoded while the result register is blocked");

endmodule

>>> tb/sv/apnsd_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the decoder, predicts one result per input transfer
// and compares every result transfer with the oldest prediction.
module apnsd_result_checker
    import apnsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_out_sample,
    input  logic               i_out_sample_valid,
    input  logic               i_out_channel,
    input  logic               i_out_last,
    input  logic               i_out_short,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_samples,
    output int                 o_full_runs,
    output int                 o_short_packets
);

    // Packet decoding state of the predictor.
    logic [16:0] pkt_pos;
    logic [15:0] pkt_len;
    logic [3:0]  shift_first;
    logic [3:0]  shift_second;
    t_esc_phase  esc_phase;
    logic [7:0]  esc_high;
    logic [11:0] pairs_done;
    logic        second_half;

    // Decoded results still owed by the block, oldest first.
    t_result expected_samples[$];

    int fail_count = 0;
    int pending = 0;
    int samples = 0;
    int full_runs = 0;
    int short_packets = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending;
    assign o_samples       = samples;
    assign o_full_runs     = full_runs;
    assign o_short_packets = short_packets;

    // Forget everything about the current packet; the shifts survive.
    task automatic clear_packet();
        pkt_pos     = '0;
        pkt_len     = '0;
        esc_phase   = ESC_NONE;
        esc_high    = '0;
        pairs_done  = '0;
        second_half = 1'b0;
    endtask

    // Steps the packet state by one byte and gives the result it causes.
    task automatic decode_byte(input logic [7:0] b, output t_result res);
        logic [15:0] widened;
        logic [3:0]  sh;
        logic        emit;
        res  = '0;
        emit = 1'b0;
        if (pkt_pos == POS_LEN_HIGH) begin
            pkt_len = {b, 8'h00};
        end else if (pkt_pos == POS_LEN_LOW) begin
            pkt_len[7:0] = b;
        end else if (pkt_pos == POS_HEADER) begin
            shift_first  = b[7:4];
            shift_second = b[3:0];
        end else if (pairs_done < PAIRS_PER_PACKET) begin
            case (esc_phase)
                ESC_HIGH: begin
                    esc_high  = b;
                    esc_phase = ESC_LOW;
                end
                ESC_LOW: begin
                    res.sample = {esc_high, b};
                    esc_phase  = ESC_NONE;
                    emit       = 1'b1;
                end
                default: begin
                    // No escape pending: either start one or shift the byte.
                    if (b == ESCAPE_BYTE) begin
                        esc_phase = ESC_HIGH;
                    end else begin
                        sh         = second_half ? shift_second : shift_first;
                        widened    = {{8{b[7]}}, b};
                        res.sample = widened << sh;
                        emit       = 1'b1;
                    end
                end
            endcase
            if (emit) begin
                res.sample_valid = 1'b1;
                res.channel      = second_half;
                if (second_half) begin
                    pairs_done = pairs_done + 12'd1;
                    if (pairs_done == PAIRS_PER_PACKET) begin
                        res.last_in_packet = 1'b1;
                    end
                end
                second_half = ~second_half;
            end
        end
        // The last byte of a packet closes it, whatever it carried.
        if (pkt_pos != POS_LEN_HIGH && pkt_pos == {1'b0, pkt_len} + 17'd1) begin
            if (pairs_done < PAIRS_PER_PACKET) begin
                res.packet_short = 1'b1;
            end
            clear_packet();
        end else begin
            pkt_pos = pkt_pos + 17'd1;
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Result transfers are checked before the input transfer of the same edge is
    // predicted; the block never returns a byte's result at its own edge.
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            clear_packet();
            shift_first  = '0;
            shift_second = '0;
            expected_samples.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual sample %h",
                             $time, i_out_sample);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    check_field("sample", want.sample, i_out_sample);
                    check_field("sample_valid", {15'd0, want.sample_valid},
                                {15'd0, i_out_sample_valid});
                    check_field("channel", {15'd0, want.channel}, {15'd0, i_out_channel});
                    check_field("last_in_packet", {15'd0, want.last_in_packet},
                                {15'd0, i_out_last});
                    check_field("packet_short", {15'd0, want.packet_short},
                                {15'd0, i_out_short});
                    if (want.sample_valid) samples++;
                    if (want.last_in_packet) full_runs++;
                    if (want.packet_short) short_packets++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data, predicted);
                expected_samples.push_back(predicted);
            end
        end
        pending = expected_samples.size();
    end

endmodule

>>> tb/sv/audio_packet_nibble_shift_decoder_test.sv
`timescale 1ns / 1ps

module audio_packet_nibble_shift_decoder_test;
    import apnsd_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int BYTES_PER_PHASE = 500;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        in_data = 8'h00;
    logic              in_chunk_end = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [15:0] out_sample;
    logic              out_sample_valid;
    logic              out_channel;
    logic              out_last;
    logic              out_short;

    int fail_count;
    int pending_results;
    int samples_seen;
    int full_runs;
    int short_packets;

    int send_idle_pct = 36;
    int recv_idle_pct = 78;
    int bytes_sent = 0;
    int packets_sent = 0;
    int cycle_count = 0;
    int hold_left = 0;
    logic hold_request = 1'b0;

    // Opening packets: an empty one, one that ends on a pending escape, one that
    // ends half way through a pair, a header-only one and one whose raw escaped
    // bytes are themselves the escape value. Shifts of 0 and 15 appear on both
    // halves of a pair.
    logic [7:0] opening_bytes [26] = '{
        8'h00, 8'h00,
        8'h00, 8'h07, 8'hF0, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h80,
        8'h00, 8'h04, 8'h0F, 8'h81, 8'h7F, 8'h00,
        8'h00, 8'h01, 8'hA5,
        8'h00, 8'h04, 8'h33, 8'h80, 8'h80, 8'h80
    };

    always #5 clk = ~clk;

    audio_packet_nibble_shift_decoder i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_data_byte      (in_data),
        .i_chunk_end      (in_chunk_end),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_sample         (out_sample),
        .o_sample_valid   (out_sample_valid),
        .o_channel        (out_channel),
        .o_last_in_packet (out_last),
        .o_packet_short   (out_short)
    );

    apnsd_result_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_in_data          (in_data),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_out_sample       (out_sample),
        .i_out_sample_valid (out_sample_valid),
        .i_out_channel      (out_channel),
        .i_out_last         (out_last),
        .i_out_short        (out_short),
        .o_fail_count       (fail_count),
        .o_pending          (pending_results),
        .o_samples          (samples_seen),
        .o_full_runs        (full_runs),
        .o_short_packets    (short_packets)
    );

    // Receiver: random stalls, or a long hold-off counted down here on request.
    always @(posedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one byte, idling at random first, and returns at its transfer.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_data      <= value;
        in_chunk_end <= ($urandom_range(7) == 0);
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Builds one packet with random content and sends it. A full run packet is
    // sized so that its last byte completes the final sample.
    task automatic send_packet(input int body_len, input bit full_run);
        logic [7:0]  body[$];
        logic [31:0] rnd;
        logic [7:0]  b;
        int          pick;
        int          sample_count;
        sample_count = 0;
        rnd = $urandom;
        body.push_back(rnd[7:0]);
        while (full_run ? sample_count < 2 * PAIRS_PER_PACKET : body.size() < body_len) begin
            pick = $urandom_range(99);
            rnd  = $urandom;
            b    = rnd[7:0];
            if (pick < 8) begin
                case (pick % 4)
                    0: b = 8'h00;
                    1: b = 8'h7F;
                    2: b = 8'h81;
                    default: b = 8'hFF;
                endcase
            end
            if (pick >= 90 || b == ESCAPE_BYTE) begin
                body.push_back(ESCAPE_BYTE);
                body.push_back(rnd[15:8]);
                body.push_back(rnd[23:16]);
            end else begin
                body.push_back(b);
            end
            sample_count++;
        end
        if (full_run) body_len = body.size();
        // Cutting the tail may leave an escape or a pair unfinished.
        while (body.size() > body_len) void'(body.pop_back());
        send_byte(body_len[15:8]);
        send_byte(body_len[7:0]);
        foreach (body[i]) send_byte(body[i]);
        packets_sent++;
    endtask

    // Stops offering and waits until every predicted result has been returned.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0) @(negedge clk);
        @(posedge clk);
    endtask

    initial begin : stimulus
        int phase_end;
        int len_pick;
        int body_len;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 78;
                    // Receiver holds off while bytes keep coming, filling the block.
                    hold_request = 1'b1;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_end = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < phase_end) begin
                len_pick = $urandom_range(99);
                if (len_pick < 5) body_len = 0;
                else if (len_pick < 65) body_len = $urandom_range(12, 1);
                else if (len_pick < 95) body_len = $urandom_range(80, 13);
                else body_len = $urandom_range(300, 81);
                send_packet(body_len, 1'b0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d bytes in %0d packets; %0d samples decoded.",
                 bytes_sent, packets_sent, samples_seen);
        $display("%0d packets ran to the full sample count, %0d ended short.",
                 full_runs, short_packets);
        if (fail_count == 0 && pending_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
